// File: hdl/cdq_pkg.sv
// shared types and codes for the circular deque
package cdq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_BACK   = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } cdq_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_t;

  localparam int unsigned ItemWidth  = 32;
  localparam int unsigned CountWidth = 5;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [ItemWidth-1:0] item_data;
  } cdq_in_t;

  typedef struct packed {
    logic [ItemWidth-1:0]  popped_data;
    logic [1:0]            status;
    logic [CountWidth-1:0] element_count;
    logic                  is_empty;
  } cdq_out_t;

  // per-cell control driven from the top level
  typedef struct packed {
    logic load;      // take the pushed element
    logic shift_up;  // take the lower neighbor's element
    logic shift_dn;  // take the upper neighbor's element
  } cdq_cell_ctl_t;

endpackage

// File: hdl/circular_deque.sv
// circular deque top level: a row of cells with the front element in cell zero
//
//   channel   ports                        handshake
//   input     start, busy, in_item         taken when start is high and busy low
//   result    out_strobe, out_result       one cycle, no back-pressure
//
// one request per cycle; busy never rises
// the result appears in the cycle after the request, from the output register
// push front and pop front shift every cell by one position in the same cycle
// push back and pop back touch the cell selected by the element count
// reset (synchronous, active low) empties the deque; cell contents are not cleared
// the receiver cannot stall, so no result is ever held back
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cdq_in_t  in_item,
  output logic     out_strobe,
  output cdq_out_t out_result
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_strobe_r;
  cdq_out_t              out_r;
  cdq_out_t              out_nxt;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] back_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] back_data;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] pop_data;
  logic [DATA_WIDTH+ItemWidth-1:0] push_ext;
  logic [DATA_WIDTH+ItemWidth-1:0] pop_ext;
  logic [CW+CountWidth-1:0]        count_ext;

  logic is_push;
  logic full;
  logic empty;
  logic req_ok;

  assign busy = 1'b0;

  assign is_push = (in_item.req_type == REQ_PUSH_BACK) ||
                   (in_item.req_type == REQ_PUSH_FRONT);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign req_ok  = start && (is_push ? !full : !empty);

  // keep only the low DATA_WIDTH bits of the pushed element
  assign push_ext  = {{DATA_WIDTH{1'b0}}, in_item.item_data};
  assign push_data = push_ext[DATA_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_cell_ctl_t         ctl;
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    assign ctl.load     = req_ok && (in_item.req_type == REQ_PUSH_BACK) &&
                          (count_r == CW'(i));
    assign ctl.shift_up = req_ok && (in_item.req_type == REQ_PUSH_FRONT);
    assign ctl.shift_dn = req_ok && (in_item.req_type == REQ_POP_FRONT);

    if (i == 0) begin : g_first
      assign lower = push_data;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_inner
      assign upper = cell_data[i+1];
    end

    // the back element sits in the cell just below the count
    assign back_tap[i] = (count_r == CW'(i + 1)) ? cell_data[i] : '0;

    cdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_data (push_data),
      .lower_data(lower),
      .upper_data(upper),
      .cell_data (cell_data[i])
    );
  end

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | back_tap[i];
    end
  end

  always_comb begin
    pop_data = '0;
    if (req_ok && (in_item.req_type == REQ_POP_FRONT)) begin
      pop_data = cell_data[0];
    end else if (req_ok && (in_item.req_type == REQ_POP_BACK)) begin
      pop_data = back_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (req_ok) begin
      count_nxt = is_push ? count_r + CW'(1) : count_r - CW'(1);
    end
  end

  assign pop_ext   = {{ItemWidth{1'b0}}, pop_data};
  assign count_ext = {{CountWidth{1'b0}}, count_nxt};

  always_comb begin
    out_nxt.popped_data   = pop_ext[ItemWidth-1:0];
    out_nxt.element_count = count_ext[CountWidth-1:0];
    out_nxt.is_empty      = (count_nxt == '0);
    if (is_push && full) begin
      out_nxt.status = ST_OVERFLOW;
    end else if (!is_push && empty) begin
      out_nxt.status = ST_UNDERFLOW;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count exceeds depth");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_strobe)
    else $error("request without result");

  a_overflow_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_result.status == ST_OVERFLOW)) |->
      (out_result.element_count == CountWidth'(DEPTH)))
    else $error("overflow reported while not full");

  a_underflow_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_result.status == ST_UNDERFLOW)) |->
      (out_result.is_empty && (out_result.popped_data == '0)))
    else $error("underflow reported while not empty");

endmodule

// File: hdl/cdq_cell.sv
// one storage cell of the deque chain, holds the element at its position
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cdq_cell_ctl_t         ctl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  output logic [DATA_WIDTH-1:0] cell_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = push_data;
    end else if (ctl.shift_up) begin
      data_nxt = lower_data;
    end else if (ctl.shift_dn) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_data = data_r;

endmodule

// File: tb/circular_deque_tb.sv
// self-checking testbench for the circular deque: directed table, then biased random requests
module circular_deque_tb;
  import cdq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 240;

  typedef struct {
    cdq_req_t    kind;
    logic [31:0] data;
    int unsigned reps;
    bit          typed;
    cdq_out_t    want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cdq_in_t  in_item;
  logic     out_strobe;
  cdq_out_t out_result;

  // predictor state
  logic [31:0] ring_mem [Depth];
  logic [3:0]  front_ptr;
  logic [3:0]  back_ptr;
  int unsigned fill_level;

  cdq_out_t    pending_results [$];
  stim_row_t   directed_plan [$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned overflows_seen;
  int unsigned underflows_seen;
  int unsigned full_seen;
  int unsigned cycle_count;
  int unsigned idle_pct;

  circular_deque #(
    .DEPTH     (Depth),
    .DATA_WIDTH(ItemWidth)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cdq_out_t predict_deque_result(cdq_in_t req);
    cdq_out_t res;
    res = '0;
    res.status = ST_OK;
    case (cdq_req_t'(req.req_type))
      REQ_PUSH_BACK: begin
        if (fill_level >= Depth) begin
          res.status = ST_OVERFLOW;
        end else begin
          ring_mem[back_ptr] = req.item_data;
          back_ptr = back_ptr + 4'd1;
          fill_level++;
        end
      end
      REQ_PUSH_FRONT: begin
        if (fill_level >= Depth) begin
          res.status = ST_OVERFLOW;
        end else begin
          front_ptr = front_ptr - 4'd1;
          ring_mem[front_ptr] = req.item_data;
          fill_level++;
        end
      end
      REQ_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          back_ptr = back_ptr - 4'd1;
          res.popped_data = ring_mem[back_ptr];
          fill_level--;
        end
      end
      default: begin
        if (fill_level == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.popped_data = ring_mem[front_ptr];
          front_ptr = front_ptr + 4'd1;
          fill_level--;
        end
      end
    endcase
    res.element_count = fill_level[CountWidth-1:0];
    res.is_empty      = (fill_level == 0);
    return res;
  endfunction

  function automatic void add_row(cdq_req_t kind, logic [31:0] data, int unsigned reps,
                                  bit typed, logic [31:0] popped, cdq_status_t status,
                                  int unsigned count, bit empty);
    stim_row_t row;
    row.kind                = kind;
    row.data                = data;
    row.reps                = reps;
    row.typed               = typed;
    row.want.popped_data    = popped;
    row.want.status         = status;
    row.want.element_count  = count[CountWidth-1:0];
    row.want.is_empty       = empty;
    directed_plan.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
             want);
    mismatches++;
  endtask

  // one request: optional idle gap, then hold start until the request is taken
  task automatic issue(cdq_in_t req, bit typed, cdq_out_t typed_want);
    cdq_out_t predicted;
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_deque_result(req);
    pending_results.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    cdq_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, popped_data", out_result.popped_data, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == ST_OVERFLOW) overflows_seen++;
        if (want.status == ST_UNDERFLOW) underflows_seen++;
        if (want.element_count == Depth) full_seen++;
        if (out_result.popped_data !== want.popped_data)
          report_mismatch("popped_data", out_result.popped_data, want.popped_data);
        if (out_result.status !== want.status)
          report_mismatch("status", 32'(out_result.status), 32'(want.status));
        if (out_result.element_count !== want.element_count)
          report_mismatch("element_count", 32'(out_result.element_count),
                          32'(want.element_count));
        if (out_result.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_result.is_empty), 32'(want.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cdq_in_t     req;
    cdq_out_t    no_want;
    int unsigned push_pct;
    int unsigned sel;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    front_ptr       = '0;
    back_ptr        = '0;
    fill_level      = 0;
    mismatches      = 0;
    requests_sent   = 0;
    results_checked = 0;
    overflows_seen  = 0;
    underflows_seen = 0;
    full_seen       = 0;
    cycle_count     = 0;
    idle_pct        = 0;
    no_want         = '0;
    push_pct        = 50;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pops on an empty deque, single-element round trips, fill to full, refused pushes, then a pop from each end
    add_row(REQ_POP_BACK,   32'h0,         1, 1'b1, 32'h0,         ST_UNDERFLOW, 0,  1'b1);
    add_row(REQ_POP_FRONT,  32'h0,         1, 1'b1, 32'h0,         ST_UNDERFLOW, 0,  1'b1);
    add_row(REQ_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1, 32'h0,         ST_OK,        1,  1'b0);
    add_row(REQ_POP_FRONT,  32'h0,         1, 1'b1, 32'hFFFF_FFFF, ST_OK,        0,  1'b1);
    add_row(REQ_PUSH_FRONT, 32'h0,         1, 1'b1, 32'h0,         ST_OK,        1,  1'b0);
    add_row(REQ_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, 32'h0,         ST_OK,        0,  1'b1);
    add_row(REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1, 1'b0, 32'h0,         ST_OK,        0,  1'b0);
    add_row(REQ_PUSH_BACK,  32'h5A5A_5A5A, 1, 1'b0, 32'h0,         ST_OK,        0,  1'b0);
    add_row(REQ_PUSH_FRONT, 32'h8000_0001, 7, 1'b0, 32'h0,         ST_OK,        0,  1'b0);
    add_row(REQ_PUSH_BACK,  32'h7FFF_FFF0, 7, 1'b0, 32'h0,         ST_OK,        0,  1'b0);
    add_row(REQ_PUSH_BACK,  32'h1234_5678, 1, 1'b1, 32'h0,         ST_OVERFLOW,  16, 1'b0);
    add_row(REQ_PUSH_FRONT, 32'h8765_4321, 1, 1'b1, 32'h0,         ST_OVERFLOW,  16, 1'b0);
    add_row(REQ_POP_FRONT,  32'h0,         1, 1'b0, 32'h0,         ST_OK,        0,  1'b0);
    add_row(REQ_POP_BACK,   32'h0,         1, 1'b0, 32'h0,         ST_OK,        0,  1'b0);

    foreach (directed_plan[r]) begin
      for (int unsigned i = 0; i < directed_plan[r].reps; i++) begin
        req.req_type  = directed_plan[r].kind;
        req.item_data = directed_plan[r].data + i;
        issue(req, directed_plan[r].typed, directed_plan[r].want);
      end
    end

    // random part: push bias changes in bursts so the fill level sweeps empty to full
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 69;
        3:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) begin
          sel = $urandom_range(3);
          push_pct = (sel == 0) ? 15 : (sel == 1) ? 85 : 50;
        end
        if ($urandom_range(99) < push_pct)
          req.req_type = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        else
          req.req_type = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
        case ($urandom_range(7))
          0:       req.item_data = '0;
          1:       req.item_data = '1;
          default: req.item_data = $urandom;
        endcase
        issue(req, 1'b0, no_want);
      end
      // hold off the sender until every outstanding result is back
      if (phase == 1) drain_pending();
    end

    drain_pending();
    repeat (4) @(posedge clk);

    $display("sent %0d requests, checked %0d results", requests_sent, results_checked);
    $display("refused pushes %0d, refused pops %0d, full-deque results %0d, mismatches %0d",
             overflows_seen, underflows_seen, full_seen, mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
